FILE: rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MPBF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication with the consequent in the next cycle
`define MPBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mpbf_pkg.sv
// types, codes and defaults for the multi pipe byte fifo
`timescale 1ns / 1ps

package mpbf_pkg;

	localparam int NUM_PIPES_DEF  = 16;
	localparam int PIPE_DEPTH_DEF = 256;

	typedef logic [1:0] req_kind_t;
	localparam req_kind_t REQ_CREATE = 2'd0;
	localparam req_kind_t REQ_WRITE  = 2'd1;
	localparam req_kind_t REQ_READ   = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_PIPE = 2'd1;
	localparam status_t ST_BLOCKED = 2'd2;

	localparam logic [15:0] MOVED_SAT = 16'hFFFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] pipe_fd;
		logic [7:0] write_byte;
		logic       burst_end;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  read_byte;
		logic [4:0]  new_read_fd;
		logic [4:0]  new_write_fd;
		logic [15:0] moved_count;
	} rsp_t;

endpackage

FILE: rtl/multi_pipe_byte_fifo.sv
// top level of the multi pipe byte fifo
//
//  channel   | handshake         | payload
//  ----------+-------------------+--------------------------------------
//  request   | start / busy      | req  (req_type, pipe_fd, write_byte,
//            |                   |       burst_end)
//  result    | done (one cycle)  | rsp  (status, read_byte, new_read_fd,
//            |                   |       new_write_fd, moved_count)
//
// the accept cycle reads the pointer ram, the next cycle modifies and
// writes it back and accesses the byte ram, and the result is on rsp with
// done in the cycle after that; no new word is taken until the modify cycle ends.
// busy is high only in the modify cycle, so the pointer read of the next
// word always sees the previous write back.
// reset clears the active map and burst counter at once; no clearing pass.
// the receiver cannot stall; done marks each result for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_pipe_byte_fifo #(
	parameter int NUM_PIPES  = mpbf_pkg::NUM_PIPES_DEF,
	parameter int PIPE_DEPTH = mpbf_pkg::PIPE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mpbf_pkg::req_t  req,
	output logic            done,
	output mpbf_pkg::rsp_t  rsp
);

	localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PTR_W  = $clog2(PIPE_DEPTH);
	localparam int CNT_W  = $clog2(PIPE_DEPTH + 1);
	localparam int ENT_W  = 2 * PTR_W + CNT_W;
	localparam int STORE  = NUM_PIPES * PIPE_DEPTH;
	localparam int ADDR_W = $clog2(STORE);

	// request decode at accept
	logic              accept;
	logic [4:0]        fd_pipe;
	logic              in_range;
	logic [PIPE_W-1:0] pipe_in;

	assign accept   = start && !busy;
	assign fd_pipe  = req.pipe_fd[5:1];
	assign in_range = (7'(fd_pipe) < 7'(NUM_PIPES));
	assign pipe_in  = in_range ? PIPE_W'(fd_pipe) : '0;

	// modify stage registers
	logic                s1_valid_q;
	mpbf_pkg::req_kind_t kind_s1;
	logic [PIPE_W-1:0]   pipe_s1;
	logic                range_s1;
	logic [7:0]          wbyte_s1;
	logic                last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req.req_type;
			pipe_s1  <= pipe_in;
			range_s1 <= in_range;
			wbyte_s1 <= req.write_byte;
			last_s1  <= req.burst_end;
		end
	end

	assign busy = s1_valid_q;

	// pointer ram: head, tail and fill count per pipe
	logic [ENT_W-1:0] ptr_rd;
	logic [ENT_W-1:0] ptr_wr;
	logic             ptr_we;
	logic [PIPE_W-1:0] ptr_waddr;

	mpbf_ram #(
		.DEPTH (NUM_PIPES),
		.WIDTH (ENT_W)
	) u_ptr_ram (
		.clk     (clk),
		.wr_en   (ptr_we),
		.wr_addr (ptr_waddr),
		.wr_data (ptr_wr),
		.rd_en   (accept),
		.rd_addr (pipe_in),
		.rd_data (ptr_rd)
	);

	// active map
	logic              look_active;
	logic              free_found;
	logic [PIPE_W-1:0] free_idx;
	logic              create_s1;

	assign create_s1 = s1_valid_q && (kind_s1 == mpbf_pkg::REQ_CREATE);

	mpbf_active #(
		.NUM_PIPES (NUM_PIPES)
	) u_active (
		.clk         (clk),
		.arst_n      (arst_n),
		.look_idx    (pipe_s1),
		.look_active (look_active),
		.free_found  (free_found),
		.free_idx    (free_idx),
		.set_en      (create_s1)
	);

	// modify logic
	logic [PTR_W-1:0]  head, tail, head_nx, tail_nx;
	logic [CNT_W-1:0]  cnt;
	logic              hit, full, empty, wr_ok, rd_ok, is_xfer;
	logic [15:0]       moved_nx;
	logic [ADDR_W-1:0] base;
	mpbf_pkg::status_t status_nx;
	logic [4:0]        rfd_nx, wfd_nx;

	assign head = ptr_rd[ENT_W-1 -: PTR_W];
	assign tail = ptr_rd[CNT_W +: PTR_W];
	assign cnt  = ptr_rd[CNT_W-1:0];

	// ring wrap at the pipe depth
	assign head_nx = (head == PTR_W'(PIPE_DEPTH - 1)) ? '0 : head + 1'b1;
	assign tail_nx = (tail == PTR_W'(PIPE_DEPTH - 1)) ? '0 : tail + 1'b1;
	assign full    = (cnt == CNT_W'(PIPE_DEPTH));
	assign empty   = (cnt == '0);
	assign hit     = range_s1 && look_active;
	assign is_xfer = (kind_s1 == mpbf_pkg::REQ_WRITE) || (kind_s1 == mpbf_pkg::REQ_READ);
	assign wr_ok   = s1_valid_q && hit && (kind_s1 == mpbf_pkg::REQ_WRITE) && !full;
	assign rd_ok   = s1_valid_q && hit && (kind_s1 == mpbf_pkg::REQ_READ) && !empty;
	assign base    = ADDR_W'(pipe_s1) * ADDR_W'(PIPE_DEPTH);

	// burst count, saturating
	logic [15:0] burst_q;
	assign moved_nx = ((wr_ok || rd_ok) && (burst_q != mpbf_pkg::MOVED_SAT)) ?
		burst_q + 16'd1 : burst_q;

	always_comb begin
		status_nx = mpbf_pkg::ST_NO_PIPE;
		rfd_nx    = '0;
		wfd_nx    = '0;
		unique case (kind_s1)
			mpbf_pkg::REQ_CREATE: begin
				if (free_found) begin
					status_nx = mpbf_pkg::ST_OK;
					rfd_nx    = 5'({free_idx, 1'b0});
					wfd_nx    = 5'({free_idx, 1'b1});
				end else begin
					status_nx = mpbf_pkg::ST_BLOCKED;
				end
			end
			mpbf_pkg::REQ_WRITE,
			mpbf_pkg::REQ_READ: begin
				if (!hit) begin
					status_nx = mpbf_pkg::ST_NO_PIPE;
				end else if (wr_ok || rd_ok) begin
					status_nx = mpbf_pkg::ST_OK;
				end else begin
					status_nx = mpbf_pkg::ST_BLOCKED;
				end
			end
			default: begin
				status_nx = mpbf_pkg::ST_NO_PIPE;
			end
		endcase
	end

	// pointer write back: a create clears the entry of the claimed pipe; a taken write or read updates its pipe
	always_comb begin
		ptr_we    = 1'b0;
		ptr_waddr = pipe_s1;
		ptr_wr    = ptr_rd;
		priority if (create_s1 && free_found) begin
			ptr_we    = 1'b1;
			ptr_waddr = free_idx;
			ptr_wr    = '0;
		end else if (wr_ok) begin
			ptr_we = 1'b1;
			ptr_wr = {head_nx, tail, cnt + 1'b1};
		end else if (rd_ok) begin
			ptr_we = 1'b1;
			ptr_wr = {head, tail_nx, cnt - 1'b1};
		end else begin
			// nothing moved, entry left as it is
			ptr_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= '0;
		end else if (s1_valid_q && is_xfer) begin
			burst_q <= last_s1 ? '0 : moved_nx;
		end
	end

	// shared byte store
	logic [7:0] byte_rd;

	mpbf_ram #(
		.DEPTH (STORE),
		.WIDTH (8)
	) u_byte_ram (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (base + ADDR_W'(head)),
		.wr_data (wbyte_s1),
		.rd_en   (rd_ok),
		.rd_addr (base + ADDR_W'(tail)),
		.rd_data (byte_rd)
	);

	// result stage
	logic              done_s2;
	mpbf_pkg::status_t status_s2;
	logic [4:0]        rfd_s2, wfd_s2;
	logic [15:0]       moved_s2;
	logic              rdok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			status_s2 <= status_nx;
			rfd_s2    <= rfd_nx;
			wfd_s2    <= wfd_nx;
			moved_s2  <= is_xfer ? moved_nx : '0;
			rdok_s2   <= rd_ok;
		end
	end

	assign done             = done_s2;
	assign rsp.status       = status_s2;
	assign rsp.read_byte    = rdok_s2 ? byte_rd : 8'd0;
	assign rsp.new_read_fd  = rfd_s2;
	assign rsp.new_write_fd = wfd_s2;
	assign rsp.moved_count  = moved_s2;

	`MPBF_ASSERT_NEXT(a_accept_enters, accept, s1_valid_q, "accepted word did not enter")
	`MPBF_ASSERT_NEXT(a_modify_to_done, s1_valid_q, done && !s1_valid_q,
		"modify cycle did not give exactly one result")
	`MPBF_ASSERT(a_fail_clean,
		!(done && rsp.status != mpbf_pkg::ST_OK) ||
		(rsp.read_byte == 8'd0 && rsp.new_read_fd == 5'd0 && rsp.new_write_fd == 5'd0),
		"failed request returned data")

endmodule

FILE: rtl/mpbf_ram.sv
// simple dual port synchronous ram, registered read
`timescale 1ns / 1ps

module mpbf_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/mpbf_active.sv
// active pipe flags with lowest free pipe search
`timescale 1ns / 1ps

module mpbf_active #(
	parameter int NUM_PIPES = mpbf_pkg::NUM_PIPES_DEF,
	localparam int PIPE_W   = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PIPE_W-1:0] look_idx,
	output logic              look_active,
	output logic              free_found,
	output logic [PIPE_W-1:0] free_idx,
	input  logic              set_en
);

	logic [NUM_PIPES-1:0] active_q;

	assign look_active = active_q[look_idx];

	// lowest inactive pipe
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = PIPE_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (set_en && free_found) begin
			active_q[free_idx] <= 1'b1;
		end
	end

endmodule

FILE: dv/multi_pipe_byte_fifo_tb.sv
// self-checking testbench for the multi pipe byte fifo
`timescale 1ns / 1ps

module multi_pipe_byte_fifo_tb;

	localparam int NUM_PIPES  = mpbf_pkg::NUM_PIPES_DEF;
	localparam int PIPE_DEPTH = mpbf_pkg::PIPE_DEPTH_DEF;

	// request code the block does not define; it must answer with no such pipe
	localparam mpbf_pkg::req_kind_t REQ_UNUSED = 2'd3;

	// words per random phase
	localparam int PHASE_WORDS = 470;

	// expected-result store plus a private copy of every pipe
	class pipe_bank_scoreboard;
		bit             active[NUM_PIPES];
		int unsigned    head[NUM_PIPES];
		int unsigned    tail[NUM_PIPES];
		int unsigned    fill[NUM_PIPES];
		logic [7:0]     bytes[NUM_PIPES * PIPE_DEPTH];
		int unsigned    burst_moved;
		mpbf_pkg::rsp_t pending[$];
		int             errors;

		function new();
			for (int i = 0; i < NUM_PIPES; i++) begin
				active[i] = 1'b0;
				head[i] = 0;
				tail[i] = 0;
				fill[i] = 0;
			end
			burst_moved = 0;
			errors = 0;
		endfunction

		function void bump_moved();
			if (burst_moved < mpbf_pkg::MOVED_SAT)
				burst_moved++;
		endfunction

		// update the pipe copy for one accepted word and queue its result
		function void note_request(mpbf_pkg::req_t w);
			mpbf_pkg::rsp_t want;
			int unsigned    p;
			bit             found;
			want = '0;
			found = 1'b0;
			case (w.req_type)
				mpbf_pkg::REQ_CREATE: begin
					want.status = mpbf_pkg::ST_BLOCKED;
					for (int i = 0; i < NUM_PIPES; i++) begin
						if (!found && !active[i]) begin
							found = 1'b1;
							active[i] = 1'b1;
							head[i] = 0;
							tail[i] = 0;
							fill[i] = 0;
							want.new_read_fd = 5'(i * 2);
							want.new_write_fd = 5'(i * 2 + 1);
							want.status = mpbf_pkg::ST_OK;
						end
					end
				end
				mpbf_pkg::REQ_WRITE, mpbf_pkg::REQ_READ: begin
					p = w.pipe_fd >> 1;
					if (p >= NUM_PIPES || !active[p]) begin
						want.status = mpbf_pkg::ST_NO_PIPE;
					end else if (w.req_type == mpbf_pkg::REQ_WRITE) begin
						if (fill[p] >= PIPE_DEPTH) begin
							want.status = mpbf_pkg::ST_BLOCKED;
						end else begin
							bytes[p * PIPE_DEPTH + head[p]] = w.write_byte;
							head[p] = (head[p] + 1) % PIPE_DEPTH;
							fill[p]++;
							bump_moved();
						end
					end else begin
						if (fill[p] == 0) begin
							want.status = mpbf_pkg::ST_BLOCKED;
						end else begin
							want.read_byte = bytes[p * PIPE_DEPTH + tail[p]];
							tail[p] = (tail[p] + 1) % PIPE_DEPTH;
							fill[p]--;
							bump_moved();
						end
					end
					want.moved_count = 16'(burst_moved);
					if (w.burst_end)
						burst_moved = 0;
				end
				default: begin
					want.status = mpbf_pkg::ST_NO_PIPE;
				end
			endcase
			pending.push_back(want);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(mpbf_pkg::rsp_t got);
			mpbf_pkg::rsp_t want;
			if (pending.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.read_byte !== want.read_byte)
				report($sformatf("read_byte got %0h want %0h", got.read_byte, want.read_byte));
			if (got.new_read_fd !== want.new_read_fd)
				report($sformatf("new_read_fd got %0d want %0d",
					got.new_read_fd, want.new_read_fd));
			if (got.new_write_fd !== want.new_write_fd)
				report($sformatf("new_write_fd got %0d want %0d",
					got.new_write_fd, want.new_write_fd));
			if (got.moved_count !== want.moved_count)
				report($sformatf("moved_count got %0d want %0d",
					got.moved_count, want.moved_count));
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	mpbf_pkg::req_t req;
	logic           done;
	mpbf_pkg::rsp_t rsp;

	pipe_bank_scoreboard sb;
	int idle_pct;
	int words_sent;

	multi_pipe_byte_fifo #(
		.NUM_PIPES (NUM_PIPES),
		.PIPE_DEPTH(PIPE_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results cannot be held off, so every done cycle is checked as it comes
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	// safety net against a hung handshake
	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic mpbf_pkg::req_t make_word(mpbf_pkg::req_kind_t kind, logic [5:0] fd,
		logic [7:0] b, logic last);
		mpbf_pkg::req_t w;
		w.req_type = kind;
		w.pipe_fd = fd;
		w.write_byte = b;
		w.burst_end = last;
		return w;
	endfunction

	// random active pipe, or -1 while none has been created
	function automatic int pick_pipe();
		int list[$];
		for (int i = 0; i < NUM_PIPES; i++)
			if (sb.active[i])
				list.push_back(i);
		if (list.size() == 0)
			return -1;
		return list[$urandom_range(list.size() - 1)];
	endfunction

	// present one word, with random sender gaps first, and wait for it to be taken
	task automatic send_word(input mpbf_pkg::req_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		@(posedge clk);
		// busy seen here is the value before this edge, which decides acceptance
		while (busy)
			@(posedge clk);
		sb.note_request(w);
		words_sent++;
	endtask

	// one multi-byte call: random bytes, burst_end on the last word only
	task automatic run_burst(input mpbf_pkg::req_kind_t kind, input logic [5:0] fd,
		input int len);
		for (int i = 0; i < len; i++)
			send_word(make_word(kind, fd, 8'($urandom), i == len - 1));
	endtask

	initial begin
		int r;
		int p;
		int n;
		int phase_idle[3];
		mpbf_pkg::req_kind_t kind;

		phase_idle[0] = 0;
		phase_idle[1] = 84;
		phase_idle[2] = 10;
		sb = new();
		idle_pct = 0;
		words_sent = 0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// nothing created yet: writes and reads see no such pipe
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd0, 8'h5A, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd1, 8'h00, 1'b1));
		send_word(make_word(REQ_UNUSED, 6'd63, 8'hFF, 1'b1));
		// create ignores its other fields
		send_word(make_word(mpbf_pkg::REQ_CREATE, 6'd63, 8'hFF, 1'b1));
		// pipe index far beyond the bank, burst kept open
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd63, 8'h11, 1'b0));
		// both descriptor parities address the same pipe
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd1, 8'h00, 1'b0));
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd0, 8'hFF, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd0, 8'h00, 1'b0));
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd1, 8'h00, 1'b0));
		// empty pipe: status blocked, count of the burst so far
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd0, 8'h00, 1'b1));
		// first index past the bank
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd32, 8'hC3, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_CREATE, 6'd0, 8'h00, 1'b0));
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd2, 8'h81, 1'b0));
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd3, 8'h00, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd3, 8'h00, 1'b0));
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd3, 8'hAA, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_CREATE, 6'd21, 8'h3C, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd5, 8'h7E, 1'b1));
		send_word(make_word(mpbf_pkg::REQ_READ, 6'd4, 8'h00, 1'b1));
		// write to a pipe that has not been created yet
		send_word(make_word(mpbf_pkg::REQ_WRITE, 6'd6, 8'h55, 1'b1));

		// random part, one phase per sender idling level
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = phase_idle[ph];
			n = words_sent + PHASE_WORDS;
			if (ph == 0) begin
				// run pipe zero into full, then drain it past empty
				run_burst(mpbf_pkg::REQ_WRITE, 6'd1, PIPE_DEPTH + 2);
				run_burst(mpbf_pkg::REQ_READ, 6'd0, PIPE_DEPTH + 2);
			end
			while (words_sent < n) begin
				r = $urandom_range(99);
				if (r < 80) begin
					p = pick_pipe();
					kind = ($urandom_range(99) < 55) ? mpbf_pkg::REQ_WRITE :
						mpbf_pkg::REQ_READ;
					if (p < 0)
						send_word(make_word(mpbf_pkg::REQ_CREATE, 6'd0, 8'd0, 1'b0));
					else
						run_burst(kind, 6'((p << 1) | $urandom_range(1)),
							$urandom_range(1, 8));
				end else if (r < 85) begin
					send_word(make_word(mpbf_pkg::REQ_CREATE, 6'($urandom_range(63)),
						8'($urandom), 1'($urandom_range(1))));
				end else begin
					// noise: any code, any descriptor, burst end at random
					send_word(make_word(mpbf_pkg::req_kind_t'($urandom_range(3)),
						6'($urandom_range(63)), 8'($urandom), 1'($urandom_range(1))));
				end
			end
		end
		start <= 1'b0;

		// drain outstanding results, then keep watching for stray strobes
		n = 0;
		while (sb.pending.size() != 0 && n < 1000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
